[rtl/mp2_pkg.sv]
package mp2_pkg;

    localparam int DATA_W     = 16;
    localparam int MAX_WIDTH  = 256;
    localparam int BUF_DEPTH  = MAX_WIDTH / 2;
    localparam int BUF_AW     = $clog2(BUF_DEPTH);
    localparam int COL_W      = BUF_AW + 1;
    localparam int ROW_W      = 12;
    localparam int CHAN_W     = 10;
    localparam int CC_W       = 11;
    localparam int IH_W       = 13;
    localparam int IW_W       = 9;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;
    localparam int MAX_CHANS  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_DIM    = 2;
    localparam int WMAX       = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;

    typedef enum logic [1:0] {
        REG_CHANNEL_COUNT = 2'd0,
        REG_INPUT_HEIGHT  = 2'd1,
        REG_INPUT_WIDTH   = 2'd2
    } t_reg_idx;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef struct packed {
        logic [CHAN_W-1:0] chan_last;
        logic [ROW_W-1:0]  row_last;
        logic [ROW_W-2:0]  out_h_last;
        logic [COL_W-1:0]  col_last;
        logic [COL_W-2:0]  out_w_last;
    } t_cfg;

    typedef struct packed {
        t_data value;
        logic  row_end;
        logic  channel_end;
        logic  frame_end;
    } t_result;

    function automatic t_data smax(input t_data a, input t_data b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_cfg cfg_decode(input logic [CC_W-1:0] cc,
                                        input logic [IH_W-1:0] ih,
                                        input logic [IW_W-1:0] iw);
        logic [CC_W-1:0] chans;
        logic [IH_W-1:0] h;
        logic [IW_W-1:0] w;
        t_cfg            c;
        if (cc == '0) begin
            chans = CC_W'(1);
        end else if (cc > CC_W'(MAX_CHANS)) begin
            chans = CC_W'(MAX_CHANS);
        end else begin
            chans = cc;
        end
        if (ih < IH_W'(MIN_DIM)) begin
            h = IH_W'(MIN_DIM);
        end else if (ih > IH_W'(MAX_HEIGHT)) begin
            h = IH_W'(MAX_HEIGHT);
        end else begin
            h = ih;
        end
        if (iw < IW_W'(MIN_DIM)) begin
            w = IW_W'(MIN_DIM);
        end else if (iw > IW_W'(WMAX)) begin
            w = IW_W'(WMAX);
        end else begin
            w = iw;
        end
        c.chan_last  = CHAN_W'(chans - CC_W'(1));
        c.row_last   = ROW_W'(h - IH_W'(1));
        c.out_h_last = (ROW_W-1)'(h[IH_W-1:1] - (IH_W-1)'(1));
        c.col_last   = COL_W'(w - IW_W'(1));
        c.out_w_last = (COL_W-1)'(w[IW_W-1:1] - (IW_W-1)'(1));
        return c;
    endfunction

endpackage

[rtl/mp2_ram.sv]
module mp2_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/mp2_ctrl.sv]
module mp2_ctrl
    import mp2_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_accept,
    input  t_data             i_sample,
    output logic              o_ram_re,
    output logic [BUF_AW-1:0] o_ram_raddr,
    output logic              o_ram_we,
    output logic [BUF_AW-1:0] o_ram_waddr,
    output t_data             o_ram_wdata,
    input  t_data             i_ram_rdata,
    output logic              o_push,
    output t_result           o_result
);

    logic [COL_W-1:0]  r_col,  n_col;
    logic [ROW_W-1:0]  r_row,  n_row;
    logic [CHAN_W-1:0] r_chan, n_chan;
    t_data             r_pair, n_pair;

    logic              in_range;
    logic [BUF_AW-1:0] slot;
    t_data             pair_m;

    assign slot     = r_col[COL_W-1:1];
    assign in_range = (slot <= i_cfg.out_w_last) && (r_row[ROW_W-1:1] <= i_cfg.out_h_last);
    assign pair_m   = smax(r_pair, i_sample);

    assign o_ram_re    = i_accept && !r_col[0];
    assign o_ram_raddr = slot;
    assign o_ram_we    = i_accept && r_col[0] && in_range && !r_row[0];
    assign o_ram_waddr = slot;
    assign o_ram_wdata = pair_m;

    assign o_push               = i_accept && r_col[0] && in_range && r_row[0];
    assign o_result.value       = smax(i_ram_rdata, pair_m);
    assign o_result.row_end     = (slot == i_cfg.out_w_last);
    assign o_result.channel_end = o_result.row_end && (r_row[ROW_W-1:1] == i_cfg.out_h_last);
    assign o_result.frame_end   = o_result.channel_end && (r_chan == i_cfg.chan_last);

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_chan = r_chan;
        n_pair = r_pair;
        if (i_accept) begin
            if (!r_col[0] && in_range) begin
                n_pair = i_sample;
            end
            if (r_col >= i_cfg.col_last) begin
                n_col = '0;
                if (r_row >= i_cfg.row_last) begin
                    n_row = '0;
                    if (r_chan >= i_cfg.chan_last) begin
                        n_chan = '0;
                    end else begin
                        n_chan = r_chan + CHAN_W'(1);
                    end
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_chan <= '0;
            r_pair <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_chan <= n_chan;
            r_pair <= n_pair;
        end
    end

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ram_we && o_ram_re))
        else $error("line buffer read and write in the same cycle");

    a_push_odd_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_col[0] && r_row[0] && !o_ram_we))
        else $error("result outside an odd row and odd column");

    a_read_before_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !o_ram_re)
        else $error("line buffer read issued on a result cycle");

endmodule

[rtl/mp2_obuf.sv]
module mp2_obuf
    import mp2_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    input  logic    i_m_ready,
    output logic    o_valid,
    output t_result o_result,
    output logic    o_s_ready
);

    logic    r_out_v,  n_out_v;
    logic    r_skid_v, n_skid_v;
    t_result r_out,    n_out;
    t_result r_skid,   n_skid;
    logic    pop;

    assign pop = r_out_v && i_m_ready;

    always_comb begin
        n_out_v  = r_out_v;
        n_skid_v = r_skid_v;
        n_out    = r_out;
        n_skid   = r_skid;
        if (!r_out_v || pop) begin
            if (r_skid_v) begin
                n_out    = r_skid;
                n_out_v  = 1'b1;
                n_skid_v = 1'b0;
            end else begin
                n_out   = i_result;
                n_out_v = i_push;
            end
        end else if (i_push) begin
            n_skid   = i_result;
            n_skid_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid   = r_out_v;
    assign o_result  = r_out;
    assign o_s_ready = !r_skid_v;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid word held with empty output register");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> !i_push)
        else $error("result pushed into a full buffer");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && pop) |=> (r_out_v && !r_skid_v && r_out == $past(r_skid)))
        else $error("skid word lost on drain");

endmodule

[rtl/max_pool_2x2_stride2_unit.sv]
// Channel   | Direction | Handshake                          | Word
// s_axis    | in        | s_axis_tvalid / s_axis_tready      | tdata[15:0] sample
// m_axis    | out       | m_axis_tvalid / m_axis_tready      | tdata pooled_value, tuser, tlast
// apb       | in        | psel, penable, pwrite, pready = 1  | registers at 0x0, 0x4, 0x8
//
// One sample is taken every cycle while s_axis_tready is high; a result is registered in the
// output buffer when the odd-column sample of an odd row that completes its window is taken.
// The line buffer is one 128-entry RAM, read on the even column and written on the odd one.
// Reset clears the counters and output valid flags and presets the registers; RAM is not cleared.
// A two-word output buffer parts the sides: s_axis_tready drops only when both words wait.
module max_pool_2x2_stride2_unit
    import mp2_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // [15:0] sample
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,   // [15:0] pooled_value
    output logic              m_axis_tlast,   // frame_end
    output logic [1:0]        m_axis_tuser,   // [0] row_end, [1] channel_end
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [CC_W-1:0]   r_channel_count;
    logic [IH_W-1:0]   r_input_height;
    logic [IW_W-1:0]   r_input_width;
    t_reg_idx          reg_idx;
    logic              cfg_wr;
    t_cfg              cfg;
    logic              accept;
    logic              ram_re, ram_we;
    logic [BUF_AW-1:0] ram_raddr, ram_waddr;
    t_data             ram_wdata, ram_rdata;
    logic              push;
    t_result           result, out_result;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= CC_W'(1);
            r_input_height  <= IH_W'(MIN_DIM);
            r_input_width   <= IW_W'(MIN_DIM);
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_CHANNEL_COUNT: r_channel_count <= pwdata[CC_W-1:0];
                REG_INPUT_HEIGHT:  r_input_height  <= pwdata[IH_W-1:0];
                REG_INPUT_WIDTH:   r_input_width   <= pwdata[IW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CHANNEL_COUNT: prdata = APB_DW'(r_channel_count);
            REG_INPUT_HEIGHT:  prdata = APB_DW'(r_input_height);
            REG_INPUT_WIDTH:   prdata = APB_DW'(r_input_width);
            default:           prdata = '0;
        endcase
    end

    assign cfg    = cfg_decode(r_channel_count, r_input_height, r_input_width);
    assign accept = s_axis_tvalid && s_axis_tready;

    mp2_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_sample    (t_data'(s_axis_tdata)),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata),
        .o_push      (push),
        .o_result    (result)
    );

    mp2_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BUF_DEPTH)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mp2_obuf u_obuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_result  (result),
        .i_m_ready (m_axis_tready),
        .o_valid   (m_axis_tvalid),
        .o_result  (out_result),
        .o_s_ready (s_axis_tready)
    );

    assign m_axis_tdata = out_result.value;
    assign m_axis_tuser = {out_result.channel_end, out_result.row_end};
    assign m_axis_tlast = out_result.frame_end;

endmodule

[tb/tb_top.sv]
module tb_top
    import mp2_pkg::*;
();

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_WORDS  = 700;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_CAP     = 50;

    typedef enum int {
        FILL_WIDE,
        FILL_TIES,
        FILL_CORNERS
    } t_fill;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata  = '0;   // [15:0] sample
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;         // [15:0] pooled_value
    logic              m_axis_tlast;         // frame_end
    logic [1:0]        m_axis_tuser;         // [0] row_end, [1] channel_end
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [APB_AW-1:0] paddr         = '0;
    logic [APB_DW-1:0] pwdata        = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // pooling state as the block should hold it
    logic [CC_W-1:0]   reg_chans  = CC_W'(1);
    logic [IH_W-1:0]   reg_height = IH_W'(2);
    logic [IW_W-1:0]   reg_width  = IW_W'(2);
    t_data             line_max [BUF_DEPTH];
    t_data             pair_even;
    int                col_pos;
    int                row_pos;
    int                chan_pos;

    logic [15:0]       pending_samples [$];
    t_result           pooled_expected [$];
    int                errors;
    int                cycle_count;
    int                send_gap;
    int                recv_gap;
    bit                steady;

    logic [15:0]       corner_words [0:23] = '{
        16'h8000, 16'h8000, 16'h8000, 16'h8000,
        16'h7fff, 16'h8000, 16'h8000, 16'h8000,
        16'h8000, 16'h7fff, 16'h8000, 16'h8000,
        16'h8000, 16'h8000, 16'h7fff, 16'h8000,
        16'h8000, 16'h8000, 16'h8000, 16'h7fff,
        16'hffff, 16'h0000, 16'haaaa, 16'h5555
    };

    max_pool_2x2_stride2_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    function automatic int bounded(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void live_dims(output int chans, output int height, output int width);
        chans  = bounded(int'(reg_chans), 1, MAX_CHANS);
        height = bounded(int'(reg_height), MIN_DIM, MAX_HEIGHT);
        width  = bounded(int'(reg_width), MIN_DIM, WMAX);
    endfunction

    function automatic t_data larger(input t_data a, input t_data b);
        return (a >= b) ? a : b;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    function automatic logic [15:0] draw_sample(input t_fill fill);
        case (fill)
            FILL_TIES: begin
                return 16'(int'($urandom_range(0, 6)) - 3);
            end
            FILL_CORNERS: begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0000;
                    3: return 16'hffff;
                    default: return 16'($urandom);
                endcase
            end
            default: begin
                return 16'($urandom);
            end
        endcase
    endfunction

    task automatic pool_sample(input t_data s);
        int      chans;
        int      height;
        int      width;
        int      slot;
        t_data   pair;
        t_result r;
        live_dims(chans, height, width);
        if (col_pos < 2 * (width / 2) && row_pos < 2 * (height / 2)) begin
            if (col_pos % 2 == 0) begin
                pair_even = s;
            end else begin
                pair = larger(pair_even, s);
                slot = col_pos / 2;
                if (row_pos % 2 == 0) begin
                    line_max[slot] = pair;
                end else begin
                    r.value       = larger(line_max[slot], pair);
                    r.row_end     = (slot == width / 2 - 1);
                    r.channel_end = r.row_end && (row_pos == 2 * (height / 2) - 1);
                    r.frame_end   = r.channel_end && (chan_pos == chans - 1);
                    pooled_expected.push_back(r);
                end
            end
        end
        if (col_pos + 1 >= width) begin
            col_pos = 0;
            if (row_pos + 1 >= height) begin
                row_pos  = 0;
                chan_pos = (chan_pos + 1 >= chans) ? 0 : chan_pos + 1;
            end else begin
                row_pos = row_pos + 1;
            end
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    task automatic report_mismatch(input string what);
        if (errors < PRINT_CAP) begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
        errors++;
    endtask

    task automatic cfg_write(input t_reg_idx idx, input int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * int'(idx));
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CHANNEL_COUNT: reg_chans  = CC_W'(value);
            REG_INPUT_HEIGHT:  reg_height = IH_W'(value);
            REG_INPUT_WIDTH:   reg_width  = IW_W'(value);
            default: ;
        endcase
    endtask

    task automatic set_shape(input int chans, input int height, input int width);
        cfg_write(REG_CHANNEL_COUNT, chans);
        cfg_write(REG_INPUT_HEIGHT, height);
        cfg_write(REG_INPUT_WIDTH, width);
    endtask

    // queue the rest of the current frame, then whole extra frames
    task automatic queue_rest(input int extra, input t_fill fill);
        int chans;
        int height;
        int width;
        int n;
        live_dims(chans, height, width);
        n = (width - col_pos) + (height - row_pos - 1) * width;
        if (chan_pos < chans) begin
            n += (chans - chan_pos - 1) * height * width;
        end
        n += extra * chans * height * width;
        repeat (n) pending_samples.push_back(draw_sample(fill));
    endtask

    task automatic settle();
        while (pending_samples.size() != 0 || s_axis_tvalid || pooled_expected.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("max_pool_2x2_stride2_unit regression: fail");
            $finish;
        end
    end

    // hold each word until taken, then leave a random gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pool_sample(t_data'(s_axis_tdata));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap != 0) begin
                    s_axis_tvalid <= 1'b0;
                    send_gap      <= send_gap - 1;
                end else if (pending_samples.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_samples.pop_front();
                    send_gap      <= (steady || $urandom_range(0, 99) < 50) ? 0 : pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap      <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pooled_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
                end else begin
                    want = pooled_expected.pop_front();
                    if (m_axis_tdata !== want.value) begin
                        report_mismatch($sformatf("pooled_value %h, expected %h",
                                                  m_axis_tdata, want.value));
                    end
                    if (m_axis_tuser[0] !== want.row_end) begin
                        report_mismatch($sformatf("row_end %b, expected %b",
                                                  m_axis_tuser[0], want.row_end));
                    end
                    if (m_axis_tuser[1] !== want.channel_end) begin
                        report_mismatch($sformatf("channel_end %b, expected %b",
                                                  m_axis_tuser[1], want.channel_end));
                    end
                    if (m_axis_tlast !== want.frame_end) begin
                        report_mismatch($sformatf("frame_end %b, expected %b",
                                                  m_axis_tlast, want.frame_end));
                    end
                end
            end
            // drop ready for a random stretch now and then
            if (recv_gap != 0) begin
                m_axis_tready <= 1'b0;
                recv_gap      <= recv_gap - 1;
            end else if (!steady && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                recv_gap      <= pick_gap() - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int    target;
        int    chans;
        int    height;
        int    width;
        int    frames;
        int    r;
        t_fill fill;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (corner_words[i]) pending_samples.push_back(corner_words[i]);
        settle();

        set_shape(0, 1, 1);
        queue_rest(1, FILL_CORNERS);
        settle();
        set_shape(2, 3, 3);
        queue_rest(1, FILL_TIES);
        settle();

        // change shape with the map half done: channel one, start of an even row
        set_shape(3, 4, 4);
        repeat (24) pending_samples.push_back(draw_sample(FILL_WIDE));
        settle();
        set_shape(1, 4, 6);
        queue_rest(0, FILL_WIDE);
        settle();

        steady = 1'b1;
        set_shape(1, 2, 511);
        queue_rest(0, FILL_TIES);
        settle();
        // run part way into oversized maps, then close them with a short shape
        set_shape(2047, 2, 2);
        repeat (24) pending_samples.push_back(draw_sample(FILL_CORNERS));
        settle();
        set_shape(1, 2, 2);
        queue_rest(0, FILL_WIDE);
        settle();
        set_shape(1, 8191, 2);
        repeat (40) pending_samples.push_back(draw_sample(FILL_TIES));
        settle();
        set_shape(1, 22, 2);
        queue_rest(0, FILL_WIDE);
        settle();
        steady = 1'b0;

        target = 0;
        while (target < RANDOM_WORDS) begin
            r      = $urandom_range(0, 99);
            frames = $urandom_range(1, 3);
            if (r < 65) begin
                chans  = $urandom_range(1, 3);
                height = $urandom_range(2, 7);
                width  = $urandom_range(2, 12);
            end else if (r < 80) begin
                chans  = $urandom_range(1, 2);
                height = $urandom_range(2, 4);
                width  = ($urandom_range(0, 3) == 0) ? $urandom_range(65, 256)
                                                     : $urandom_range(13, 64);
                frames = 1;
            end else if (r < 93) begin
                chans  = $urandom_range(2, 8);
                height = $urandom_range(2, 3);
                width  = $urandom_range(2, 4);
            end else begin
                chans  = 0;
                height = $urandom_range(0, 1);
                width  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1)
                                                     : $urandom_range(257, 511);
                frames = 1;
            end
            steady = ($urandom_range(0, 4) == 0);
            fill   = t_fill'($urandom_range(0, 2));
            set_shape(chans, height, width);
            queue_rest(frames - 1, fill);
            live_dims(chans, height, width);
            target += frames * chans * (height / 2) * (width / 2) * 4;
            settle();
        end

        settle();
        if (errors == 0) begin
            $display("max_pool_2x2_stride2_unit regression: pass");
        end else begin
            $display("max_pool_2x2_stride2_unit regression: fail");
        end
        $finish;
    end

endmodule
